>>> src/ecpa_pkg.sv
// ----------------------------------------------------------------------------
// ecpa_pkg
// Shared types, constants and the field-operation microprogram for the
// affine elliptic-curve point arithmetic block.
// ----------------------------------------------------------------------------
package ecpa_pkg;

	localparam int FIELD_WIDTH  = 32;
	localparam int SCALAR_WIDTH = 32;
	localparam int MCNT_W       = $clog2(FIELD_WIDTH);
	localparam int PC_W         = 5;
	localparam int CFG_IDX_W    = 2;

	typedef logic [FIELD_WIDTH-1:0]  fe_t;
	typedef logic [SCALAR_WIDTH-1:0] scal_t;
	typedef logic [3:0]              reg_addr_t;
	typedef logic [PC_W-1:0]         pc_t;

	// register file map
	localparam reg_addr_t R_AX = 4'd0;
	localparam reg_addr_t R_AY = 4'd1;
	localparam reg_addr_t R_DX = 4'd2;
	localparam reg_addr_t R_DY = 4'd3;
	localparam reg_addr_t R_CA = 4'd4;
	localparam reg_addr_t R_Z  = 4'd5;
	localparam reg_addr_t R_T0 = 4'd6;
	localparam reg_addr_t R_T1 = 4'd7;
	localparam reg_addr_t R_T2 = 4'd8;
	localparam reg_addr_t R_T3 = 4'd9;

	// operation codes
	localparam logic [1:0] FN_ADD = 2'd0;
	localparam logic [1:0] FN_DBL = 2'd1;
	localparam logic [1:0] FN_MUL = 2'd2;
	localparam logic [1:0] FN_NOP = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_EQX = 2'd1;
	localparam logic [1:0] ST_DB0 = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_A   = 2'd1;

	localparam fe_t MOD_RESET = fe_t'(23);
	localparam fe_t A_RESET   = fe_t'(1);

	// program entry points
	localparam pc_t PC_ADD = 5'd0;
	localparam pc_t PC_DBL = 5'd12;
	localparam pc_t PC_CPY = 5'd27;

	typedef enum logic [2:0] {
		UOP_ADD,
		UOP_SUB,
		UOP_MUL,
		UOP_INV,
		UOP_END
	} uop_t;

	typedef struct packed {
		uop_t       op;
		reg_addr_t  d;
		reg_addr_t  a;
		reg_addr_t  b;
		logic [1:0] chk_st;
	} instr_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LOAD,
		S_ZERO,
		S_DISP,
		S_KBIT,
		S_KDBL,
		S_RA,
		S_RB,
		S_OPB,
		S_MUL,
		S_INVB,
		S_INVM,
		S_WB,
		S_OUTX,
		S_OUTY,
		S_OUTW,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		PH_ADD,
		PH_DBL,
		PH_KCPY,
		PH_KADD,
		PH_KDBL
	} phase_t;

	function automatic instr_t mk(uop_t op, reg_addr_t d, reg_addr_t a, reg_addr_t b,
			logic [1:0] chk);
		instr_t i;
		i.op     = op;
		i.d      = d;
		i.a      = a;
		i.b      = b;
		i.chk_st = chk;
		return i;
	endfunction

	// microprogram: A = A + D, D = 2D, A = D
	function automatic instr_t rom(pc_t pc);
		instr_t i;
		unique case (pc)
			// point addition, accumulator plus doubled point
			5'd0:  i = mk(UOP_SUB, R_T0, R_DX, R_AX, ST_EQX);
			5'd1:  i = mk(UOP_INV, R_T0, R_T0, R_T0, ST_OK);
			5'd2:  i = mk(UOP_SUB, R_T1, R_DY, R_AY, ST_OK);
			5'd3:  i = mk(UOP_MUL, R_T2, R_T1, R_T0, ST_OK);
			5'd4:  i = mk(UOP_MUL, R_T1, R_T2, R_T2, ST_OK);
			5'd5:  i = mk(UOP_SUB, R_T1, R_T1, R_AX, ST_OK);
			5'd6:  i = mk(UOP_SUB, R_T3, R_T1, R_DX, ST_OK);
			5'd7:  i = mk(UOP_SUB, R_T1, R_AX, R_T3, ST_OK);
			5'd8:  i = mk(UOP_MUL, R_T1, R_T2, R_T1, ST_OK);
			5'd9:  i = mk(UOP_SUB, R_AY, R_T1, R_AY, ST_OK);
			5'd10: i = mk(UOP_SUB, R_AX, R_T3, R_Z,  ST_OK);
			5'd11: i = mk(UOP_END, R_Z,  R_Z,  R_Z,  ST_OK);
			// point doubling
			5'd12: i = mk(UOP_ADD, R_T0, R_DY, R_DY, ST_DB0);
			5'd13: i = mk(UOP_INV, R_T0, R_T0, R_T0, ST_OK);
			5'd14: i = mk(UOP_MUL, R_T1, R_DX, R_DX, ST_OK);
			5'd15: i = mk(UOP_ADD, R_T3, R_T1, R_T1, ST_OK);
			5'd16: i = mk(UOP_ADD, R_T3, R_T3, R_T1, ST_OK);
			5'd17: i = mk(UOP_ADD, R_T3, R_T3, R_CA, ST_OK);
			5'd18: i = mk(UOP_MUL, R_T2, R_T3, R_T0, ST_OK);
			5'd19: i = mk(UOP_MUL, R_T1, R_T2, R_T2, ST_OK);
			5'd20: i = mk(UOP_SUB, R_T1, R_T1, R_DX, ST_OK);
			5'd21: i = mk(UOP_SUB, R_T3, R_T1, R_DX, ST_OK);
			5'd22: i = mk(UOP_SUB, R_T1, R_DX, R_T3, ST_OK);
			5'd23: i = mk(UOP_MUL, R_T1, R_T2, R_T1, ST_OK);
			5'd24: i = mk(UOP_SUB, R_DY, R_T1, R_DY, ST_OK);
			5'd25: i = mk(UOP_SUB, R_DX, R_T3, R_Z,  ST_OK);
			5'd26: i = mk(UOP_END, R_Z,  R_Z,  R_Z,  ST_OK);
			// accumulator takes the doubled point
			5'd27: i = mk(UOP_SUB, R_AX, R_DX, R_Z,  ST_OK);
			5'd28: i = mk(UOP_SUB, R_AY, R_DY, R_Z,  ST_OK);
			default: i = mk(UOP_END, R_Z, R_Z, R_Z, ST_OK);
		endcase
		return i;
	endfunction

endpackage

>>> src/ecpa_if.sv
// ----------------------------------------------------------------------------
// ecpa channel interfaces
// Request, response and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface ecpa_req_if;
	logic                 valid;
	logic                 ready;
	logic [1:0]           func;
	ecpa_pkg::fe_t        px;
	ecpa_pkg::fe_t        py;
	ecpa_pkg::fe_t        qx;
	ecpa_pkg::fe_t        qy;
	ecpa_pkg::scal_t      scalar_k;
	modport source (output valid, func, px, py, qx, qy, scalar_k, input ready);
	modport sink   (input valid, func, px, py, qx, qy, scalar_k, output ready);
endinterface

interface ecpa_rsp_if;
	logic          valid;
	logic          ready;
	ecpa_pkg::fe_t rx;
	ecpa_pkg::fe_t ry;
	logic [1:0]    status;
	modport source (output valid, rx, ry, status, input ready);
	modport sink   (input valid, rx, ry, status, output ready);
endinterface

interface ecpa_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [ecpa_pkg::CFG_IDX_W-1:0]     index;
	ecpa_pkg::fe_t                      data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> src/ecc_point_arith_prime_field_top.sv
// ----------------------------------------------------------------------------
// ecc_point_arith_prime_field_top
// Affine point add, double and scalar multiply over GF(p), microcoded over a
// small register file with a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Operation: each input is reduced through the bit-serial multiplier, an
// inverse takes up to 2*FIELD_WIDTH field multiplies, and a scalar multiply
// runs up to SCALAR_WIDTH add/double rounds.
// Throughput: one item at a time, bound by the one-bit-per-cycle multiplier.
// Reset: modulus 23, coefficient 1, no result pending; register file undefined.
module ecc_point_arith_prime_field_top (
	input  logic       clk,
	input  logic       arst_n,
	ecpa_cfg_if.sink   cfg,
	ecpa_req_if.sink   req,
	ecpa_rsp_if.source rsp
);

	localparam int FW = ecpa_pkg::FIELD_WIDTH;

	ecpa_pkg::state_t state_q, state_d;
	ecpa_pkg::phase_t phase_q;
	ecpa_pkg::pc_t    pc_q;
	ecpa_pkg::instr_t instr;

	ecpa_pkg::fe_t    mod_q, coeff_q;
	logic [1:0]       func_q, status_q, st_q;
	ecpa_pkg::scal_t  k_q;
	logic             acc_set_q, d_inf_q, zero_q, out_valid_q;
	ecpa_pkg::fe_t    raw_py_q, raw_qx_q, raw_qy_q;
	logic [2:0]       ld_q;

	// register file
	ecpa_pkg::fe_t      rf_mem [16];
	ecpa_pkg::fe_t      rd_data_q;
	ecpa_pkg::reg_addr_t raddr, waddr;
	ecpa_pkg::fe_t      wdata;
	logic               we;

	// datapath registers
	ecpa_pkg::fe_t    opa_q, res_q, inv_r_q, inv_b_q, inv_e_q;
	ecpa_pkg::fe_t    res_x_q, res_y_q, rx_q, ry_q;
	ecpa_pkg::fe_t    ma_q, mb_q, mr_q;
	logic [ecpa_pkg::MCNT_W-1:0] mcnt_q;
	logic             red_q, isel_q;

	assign instr = ecpa_pkg::rom(pc_q);

	// bit-serial modular multiply / reduce step
	logic [FW+1:0] m_add_w, m_s, m1, m2;
	ecpa_pkg::fe_t mres;
	logic          mul_last;
	always_comb begin
		m1 = {2'b00, mod_q};
		m2 = {1'b0, mod_q, 1'b0};
		if (red_q)
			m_add_w = {{(FW+1){1'b0}}, mb_q[FW-1]};
		else
			m_add_w = mb_q[FW-1] ? {2'b00, ma_q} : '0;
		m_s = {1'b0, mr_q, 1'b0} + m_add_w;
		if (m_s >= m2)
			m_s = m_s - m2;
		else if (m_s >= m1)
			m_s = m_s - m1;
		mres     = m_s[FW-1:0];
		mul_last = (mcnt_q == ecpa_pkg::MCNT_W'(FW-1));
	end

	// modular add / subtract of the two operands
	ecpa_pkg::fe_t alu;
	logic [FW:0]   alu_s;
	always_comb begin
		alu_s = {1'b0, opa_q} + {1'b0, rd_data_q};
		if (instr.op == ecpa_pkg::UOP_ADD)
			alu = (alu_s >= {1'b0, mod_q}) ? FW'(alu_s - {1'b0, mod_q}) : alu_s[FW-1:0];
		else if (opa_q >= rd_data_q)
			alu = opa_q - rd_data_q;
		else
			alu = opa_q - rd_data_q + mod_q;
	end

	// load sequencing
	ecpa_pkg::fe_t       ld_next;
	ecpa_pkg::reg_addr_t ld_dst;
	always_comb begin
		unique case (ld_q)
			3'd0:    ld_next = raw_py_q;
			3'd1:    ld_next = raw_qx_q;
			3'd2:    ld_next = raw_qy_q;
			default: ld_next = coeff_q;
		endcase
		if (ld_q == 3'd4)
			ld_dst = ecpa_pkg::R_CA;
		else if (func_q == ecpa_pkg::FN_ADD)
			ld_dst = ecpa_pkg::reg_addr_t'(ld_q);
		else
			ld_dst = ecpa_pkg::reg_addr_t'(ld_q) ^ 4'd2;
	end

	logic wb_abort, res_use_a, res_zero;
	assign wb_abort  = (instr.chk_st != ecpa_pkg::ST_OK) && (res_q == '0);
	assign res_use_a = (func_q != ecpa_pkg::FN_DBL);
	assign res_zero  = zero_q || ((func_q != ecpa_pkg::FN_MUL) && (status_q != ecpa_pkg::ST_OK))
		|| ((func_q == ecpa_pkg::FN_MUL) && !acc_set_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ecpa_pkg::S_IDLE: if (req.valid) state_d = ecpa_pkg::S_LOAD;
			ecpa_pkg::S_LOAD: if (mul_last && ld_q == 3'd4) state_d = ecpa_pkg::S_ZERO;
			ecpa_pkg::S_ZERO: state_d = ecpa_pkg::S_DISP;
			ecpa_pkg::S_DISP: begin
				if (zero_q || mod_q < ecpa_pkg::fe_t'(2) || func_q == ecpa_pkg::FN_NOP)
					state_d = ecpa_pkg::S_DONE;
				else if (func_q == ecpa_pkg::FN_MUL)
					state_d = ecpa_pkg::S_KBIT;
				else
					state_d = ecpa_pkg::S_RA;
			end
			ecpa_pkg::S_KBIT: begin
				if (k_q == '0)
					state_d = ecpa_pkg::S_OUTX;
				else if (k_q[0] && (!acc_set_q || !d_inf_q))
					state_d = ecpa_pkg::S_RA;
				else
					state_d = ecpa_pkg::S_KDBL;
			end
			ecpa_pkg::S_KDBL: begin
				if ((k_q >> 1) != '0 && !d_inf_q)
					state_d = ecpa_pkg::S_RA;
				else
					state_d = ecpa_pkg::S_KBIT;
			end
			ecpa_pkg::S_RA: begin
				if (instr.op == ecpa_pkg::UOP_END) begin
					unique case (phase_q)
						ecpa_pkg::PH_ADD, ecpa_pkg::PH_DBL: state_d = ecpa_pkg::S_OUTX;
						ecpa_pkg::PH_KCPY, ecpa_pkg::PH_KADD: state_d = ecpa_pkg::S_KDBL;
						default: state_d = ecpa_pkg::S_KBIT;
					endcase
				end else
					state_d = ecpa_pkg::S_RB;
			end
			ecpa_pkg::S_RB: state_d = ecpa_pkg::S_OPB;
			ecpa_pkg::S_OPB: begin
				unique case (instr.op)
					ecpa_pkg::UOP_MUL: state_d = ecpa_pkg::S_MUL;
					ecpa_pkg::UOP_INV: state_d = ecpa_pkg::S_INVB;
					default:           state_d = ecpa_pkg::S_WB;
				endcase
			end
			ecpa_pkg::S_MUL:  if (mul_last) state_d = ecpa_pkg::S_WB;
			ecpa_pkg::S_INVB: state_d = (inv_e_q == '0) ? ecpa_pkg::S_WB : ecpa_pkg::S_INVM;
			ecpa_pkg::S_INVM: if (mul_last && isel_q) state_d = ecpa_pkg::S_INVB;
			ecpa_pkg::S_WB: begin
				if (wb_abort) begin
					unique case (phase_q)
						ecpa_pkg::PH_ADD, ecpa_pkg::PH_DBL: state_d = ecpa_pkg::S_OUTX;
						ecpa_pkg::PH_KCPY, ecpa_pkg::PH_KADD: state_d = ecpa_pkg::S_KDBL;
						default: state_d = ecpa_pkg::S_KBIT;
					endcase
				end else
					state_d = ecpa_pkg::S_RA;
			end
			ecpa_pkg::S_OUTX: state_d = ecpa_pkg::S_OUTY;
			ecpa_pkg::S_OUTY: state_d = ecpa_pkg::S_OUTW;
			ecpa_pkg::S_OUTW: state_d = ecpa_pkg::S_DONE;
			ecpa_pkg::S_DONE: if (!out_valid_q || rsp.ready) state_d = ecpa_pkg::S_IDLE;
			default: state_d = ecpa_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req.ready = (state_q == ecpa_pkg::S_IDLE);
		we        = 1'b0;
		waddr     = ecpa_pkg::R_Z;
		wdata     = res_q;
		raddr     = instr.a;
		unique case (state_q)
			ecpa_pkg::S_LOAD: begin
				we    = mul_last;
				waddr = ld_dst;
				wdata = mres;
			end
			ecpa_pkg::S_ZERO: begin
				we    = 1'b1;
				waddr = ecpa_pkg::R_Z;
				wdata = '0;
			end
			ecpa_pkg::S_RB: raddr = instr.b;
			ecpa_pkg::S_WB: begin
				we    = 1'b1;
				waddr = instr.d;
			end
			ecpa_pkg::S_OUTX: raddr = res_use_a ? ecpa_pkg::R_AX : ecpa_pkg::R_DX;
			ecpa_pkg::S_OUTY: raddr = res_use_a ? ecpa_pkg::R_AY : ecpa_pkg::R_DY;
			default: ;
		endcase
	end

	// register file, one write and one registered read
	always_ff @(posedge clk) begin
		if (we)
			rf_mem[waddr] <= wdata;
		rd_data_q <= rf_mem[raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ecpa_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			mod_q       <= ecpa_pkg::MOD_RESET;
			coeff_q     <= ecpa_pkg::A_RESET;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				if (cfg.index == ecpa_pkg::CFG_MOD)
					mod_q <= cfg.data;
				else if (cfg.index == ecpa_pkg::CFG_A)
					coeff_q <= cfg.data;
			end
			if (state_q == ecpa_pkg::S_DONE && (!out_valid_q || rsp.ready))
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign cfg.ready  = 1'b1;
	assign rsp.valid  = out_valid_q;
	assign rsp.rx     = rx_q;
	assign rsp.ry     = ry_q;
	assign rsp.status = st_q;

	// datapath and sequencing registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ecpa_pkg::S_IDLE: begin
				func_q    <= req.func;
				raw_py_q  <= req.py;
				raw_qx_q  <= req.qx;
				raw_qy_q  <= req.qy;
				k_q       <= req.scalar_k;
				acc_set_q <= 1'b0;
				d_inf_q   <= 1'b0;
				zero_q    <= 1'b0;
				status_q  <= ecpa_pkg::ST_OK;
				ld_q      <= 3'd0;
				mr_q      <= '0;
				mcnt_q    <= '0;
				mb_q      <= req.px;
				red_q     <= 1'b1;
			end
			ecpa_pkg::S_LOAD: begin
				if (mul_last) begin
					ld_q   <= ld_q + 3'd1;
					mr_q   <= '0;
					mcnt_q <= '0;
					mb_q   <= ld_next;
				end else begin
					mcnt_q <= mcnt_q + 1'b1;
					mb_q   <= mb_q << 1;
					mr_q   <= mres;
				end
			end
			ecpa_pkg::S_DISP: begin
				red_q <= 1'b0;
				if (mod_q < ecpa_pkg::fe_t'(2) || func_q == ecpa_pkg::FN_NOP)
					zero_q <= 1'b1;
				phase_q <= (func_q == ecpa_pkg::FN_DBL) ? ecpa_pkg::PH_DBL : ecpa_pkg::PH_ADD;
				pc_q    <= (func_q == ecpa_pkg::FN_DBL) ? ecpa_pkg::PC_DBL : ecpa_pkg::PC_ADD;
			end
			ecpa_pkg::S_KBIT: begin
				if (k_q[0] && !acc_set_q) begin
					acc_set_q <= 1'b1;
					phase_q   <= ecpa_pkg::PH_KCPY;
					pc_q      <= ecpa_pkg::PC_CPY;
				end else begin
					phase_q <= ecpa_pkg::PH_KADD;
					pc_q    <= ecpa_pkg::PC_ADD;
				end
			end
			ecpa_pkg::S_KDBL: begin
				k_q     <= k_q >> 1;
				phase_q <= ecpa_pkg::PH_KDBL;
				pc_q    <= ecpa_pkg::PC_DBL;
			end
			ecpa_pkg::S_RB: opa_q <= rd_data_q;
			ecpa_pkg::S_OPB: begin
				res_q   <= alu;
				ma_q    <= opa_q;
				mb_q    <= rd_data_q;
				mr_q    <= '0;
				mcnt_q  <= '0;
				inv_r_q <= ecpa_pkg::fe_t'(1);
				inv_b_q <= opa_q;
				inv_e_q <= mod_q - ecpa_pkg::fe_t'(2);
			end
			ecpa_pkg::S_MUL: begin
				mcnt_q <= mcnt_q + 1'b1;
				mb_q   <= mb_q << 1;
				mr_q   <= mres;
				if (mul_last)
					res_q <= mres;
			end
			ecpa_pkg::S_INVB: begin
				res_q  <= inv_r_q;
				mr_q   <= '0;
				mcnt_q <= '0;
				isel_q <= !inv_e_q[0];
				ma_q   <= inv_e_q[0] ? inv_r_q : inv_b_q;
				mb_q   <= inv_b_q;
			end
			ecpa_pkg::S_INVM: begin
				if (mul_last) begin
					mr_q   <= '0;
					mcnt_q <= '0;
					if (!isel_q) begin
						inv_r_q <= mres;
						isel_q  <= 1'b1;
						ma_q    <= inv_b_q;
						mb_q    <= inv_b_q;
					end else begin
						inv_b_q <= mres;
						inv_e_q <= inv_e_q >> 1;
					end
				end else begin
					mcnt_q <= mcnt_q + 1'b1;
					mb_q   <= mb_q << 1;
					mr_q   <= mres;
				end
			end
			ecpa_pkg::S_WB: begin
				if (wb_abort) begin
					if (status_q == ecpa_pkg::ST_OK)
						status_q <= instr.chk_st;
					if (phase_q == ecpa_pkg::PH_KDBL)
						d_inf_q <= 1'b1;
				end else
					pc_q <= pc_q + 1'b1;
			end
			ecpa_pkg::S_OUTY: res_x_q <= rd_data_q;
			ecpa_pkg::S_OUTW: res_y_q <= rd_data_q;
			ecpa_pkg::S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					rx_q <= res_zero ? '0 : res_x_q;
					ry_q <= res_zero ? '0 : res_y_q;
					st_q <= zero_q ? ecpa_pkg::ST_OK : status_q;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> tb/tb_ecpa_ifs.sv
// ----------------------------------------------------------------------------
// testbench channel wiring
// Instantiates nothing itself; the channel interfaces come from the RTL
// sources. This file holds the request and result item types shared by driver, predictor and monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tb_ecpa_pkg;
	import ecpa_pkg::*;

	typedef struct {
		logic [1:0] func;
		fe_t        px;
		fe_t        py;
		fe_t        qx;
		fe_t        qy;
		scal_t      k;
	} point_op_t;

	typedef struct {
		fe_t        rx;
		fe_t        ry;
		logic [1:0] status;
	} point_res_t;
endpackage

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives point add, double, scalar multiply and no-op requests through the
// block, predicts each result with a behavioural model of the curve
// arithmetic and compares every response transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
	import ecpa_pkg::*;
	import tb_ecpa_pkg::*;

	localparam int IDLE_PCT   = 21;
	localparam int STALL_LIM  = 1000000;
	localparam int DRAIN_CYC  = 200;

	logic clk;
	logic arst_n;

	ecpa_cfg_if cfg ();
	ecpa_req_if req ();
	ecpa_rsp_if rsp ();

	ecc_point_arith_prime_field_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg.sink),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// model copy of the configuration
	logic [63:0] modulus;
	logic [63:0] coeff_a;

	point_op_t  op_q[$];
	point_res_t result_q[$];
	int         errors;
	bit         no_idle;
	bit         hold_req;
	int         quiet_cycles;

	// clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------- field arithmetic ----------------
	function automatic logic [63:0] f_add(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [64:0] s;
		s = a + b;
		if (s >= m)
			s = s - m;
		return s[63:0];
	endfunction

	function automatic logic [63:0] f_sub(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		if (a >= b)
			return a - b;
		return (m - b) + a;
	endfunction

	function automatic logic [63:0] f_mul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [127:0] p;
		p = a * b;
		return p % m;
	endfunction

	function automatic logic [63:0] f_inv(logic [63:0] a, logic [63:0] m);
		logic [63:0] e;
		logic [63:0] r;
		logic [63:0] bs;
		e  = m - 2;
		r  = 1 % m;
		bs = a;
		while (e != 0) begin
			if (e[0])
				r = f_mul(r, bs, m);
			bs = f_mul(bs, bs, m);
			e  = e >> 1;
		end
		return r;
	endfunction

	function automatic logic [1:0] pt_sum(logic [63:0] x1, logic [63:0] y1,
			logic [63:0] x2, logic [63:0] y2, logic [63:0] m,
			inout logic [63:0] rx, inout logic [63:0] ry);
		logic [63:0] lam;
		logic [63:0] x3;
		if (x1 == x2)
			return ST_EQX;
		lam = f_mul(f_sub(y2, y1, m), f_inv(f_sub(x2, x1, m), m), m);
		x3  = f_sub(f_sub(f_mul(lam, lam, m), x1, m), x2, m);
		ry  = f_sub(f_mul(lam, f_sub(x1, x3, m), m), y1, m);
		rx  = x3;
		return ST_OK;
	endfunction

	function automatic logic [1:0] pt_twice(logic [63:0] x, logic [63:0] y,
			logic [63:0] a, logic [63:0] m,
			inout logic [63:0] rx, inout logic [63:0] ry);
		logic [63:0] den;
		logic [63:0] t;
		logic [63:0] num;
		logic [63:0] lam;
		logic [63:0] x3;
		den = f_add(y, y, m);
		if (den == 0)
			return ST_DB0;
		t   = f_mul(x, x, m);
		num = f_add(f_add(f_add(t, t, m), t, m), a, m);
		lam = f_mul(num, f_inv(den, m), m);
		x3  = f_sub(f_sub(f_mul(lam, lam, m), x, m), x, m);
		ry  = f_sub(f_mul(lam, f_sub(x, x3, m), m), y, m);
		rx  = x3;
		return ST_OK;
	endfunction

	// expected curve result for one request
	function automatic point_res_t curve_result(point_op_t op);
		point_res_t  res;
		logic [63:0] m;
		logic [63:0] px, py, qx, qy, a, k;
		logic [63:0] dx, dy, ax, ay, nx, ny;
		logic [1:0]  st, s;
		bit          d_inf, acc_set;
		m  = modulus;
		st = ST_OK;
		ax = 0;
		ay = 0;
		res.rx = '0;
		res.ry = '0;
		res.status = ST_OK;
		if (m < 2)
			return res;
		px = op.px % m;
		py = op.py % m;
		qx = op.qx % m;
		qy = op.qy % m;
		k  = op.k;
		a  = coeff_a % m;
		if (op.func == FN_ADD) begin
			st = pt_sum(px, py, qx, qy, m, ax, ay);
		end else if (op.func == FN_DBL) begin
			st = pt_twice(px, py, a, m, ax, ay);
		end else if (op.func == FN_MUL) begin
			dx = px;
			dy = py;
			d_inf = 0;
			acc_set = 0;
			while (k != 0) begin
				if (k[0]) begin
					if (!acc_set) begin
						ax = dx;
						ay = dy;
						acc_set = 1;
					end else if (!d_inf) begin
						nx = ax;
						ny = ay;
						s = pt_sum(ax, ay, dx, dy, m, nx, ny);
						if (s == ST_OK) begin
							ax = nx;
							ay = ny;
						end else if (st == ST_OK)
							st = s;
					end
				end
				k = k >> 1;
				if (k != 0 && !d_inf) begin
					nx = dx;
					ny = dy;
					s = pt_twice(dx, dy, a, m, nx, ny);
					if (s == ST_OK) begin
						dx = nx;
						dy = ny;
					end else begin
						d_inf = 1;
						if (st == ST_OK)
							st = s;
					end
				end
			end
		end
		if (st != ST_OK && op.func != FN_MUL) begin
			ax = 0;
			ay = 0;
		end
		res.rx = ax[FIELD_WIDTH-1:0];
		res.ry = ay[FIELD_WIDTH-1:0];
		res.status = st;
		return res;
	endfunction

	// ---------------- request driver ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid    <= 1'b0;
			req.func     <= '0;
			req.px       <= '0;
			req.py       <= '0;
			req.qx       <= '0;
			req.qy       <= '0;
			req.scalar_k <= '0;
		end else begin
			if (req.valid && req.ready) begin
				point_op_t cur;
				cur.func = req.func;
				cur.px   = req.px;
				cur.py   = req.py;
				cur.qx   = req.qx;
				cur.qy   = req.qy;
				cur.k    = req.scalar_k;
				result_q.push_back(curve_result(cur));
			end
			if (!req.valid || req.ready) begin
				if (op_q.size() > 0 && !hold_req
						&& (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
					point_op_t nxt;
					nxt = op_q.pop_front();
					req.valid    <= 1'b1;
					req.func     <= nxt.func;
					req.px       <= nxt.px;
					req.py       <= nxt.py;
					req.qx       <= nxt.qx;
					req.qy       <= nxt.qy;
					req.scalar_k <= nxt.k;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- response monitor ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result rx=%h ry=%h status=%0d",
						$time, rsp.rx, rsp.ry, rsp.status);
					errors++;
				end else begin
					point_res_t want;
					want = result_q.pop_front();
					if (rsp.rx !== want.rx) begin
						$display("%0t: rx expected %h actual %h", $time, want.rx, rsp.rx);
						errors++;
					end
					if (rsp.ry !== want.ry) begin
						$display("%0t: ry expected %h actual %h", $time, want.ry, rsp.ry);
						errors++;
					end
					if (rsp.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
						errors++;
					end
				end
			end
			rsp.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// ---------------- watchdog ----------------
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)
				|| (cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIM) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// register write, only while the block is idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, fe_t value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == CFG_MOD)
			modulus = value;
		else
			coeff_a = value;
	endtask

	task automatic drain();
		wait (op_q.size() == 0 && !req.valid);
		wait (result_q.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic queue_op(logic [1:0] f, fe_t px, fe_t py, fe_t qx, fe_t qy, scal_t k);
		point_op_t o;
		o.func = f;
		o.px = px;
		o.py = py;
		o.qx = qx;
		o.qy = qy;
		o.k  = k;
		op_q.push_back(o);
	endtask

	// random items; small scalars when small_k is set, on-curve style content not needed
	task automatic queue_random(int n, bit small_k);
		scal_t k;
		for (int i = 0; i < n; i++) begin
			k = small_k ? scal_t'($urandom_range(255)) : scal_t'($urandom);
			queue_op(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom, k);
		end
	endtask

	// ---------------- stimulus ----------------
	initial begin
		errors    = 0;
		no_idle   = 0;
		hold_req  = 0;
		modulus   = MOD_RESET;
		coeff_a   = A_RESET;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data  = '0;
		arst_n    = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset configuration p = 23, a = 1
		queue_op(FN_ADD, 3, 10, 9, 7, 0);
		queue_op(FN_ADD, 3, 10, 26, 5, 0);           // equal x after reduction
		queue_op(FN_DBL, 3, 10, 0, 0, 0);
		queue_op(FN_DBL, 5, 0, 0, 0, 0);             // doubling with y zero
		queue_op(FN_DBL, 5, 23, 0, 0, 0);
		queue_op(FN_MUL, 3, 10, 0, 0, 0);            // scalar zero
		queue_op(FN_MUL, 3, 10, 0, 0, 1);
		queue_op(FN_MUL, 3, 10, 0, 0, 7);
		queue_op(FN_MUL, 3, 10, 0, 0, 28);
		queue_op(FN_MUL, 5, 0, 0, 0, 6);             // doubled point becomes infinity
		queue_op(FN_MUL, 3, 10, 0, 0, '1);
		queue_op(FN_NOP, 3, 10, 9, 7, 5);            // unused operation code
		queue_op(FN_ADD, '1, '1, '0, '0, '1);
		queue_op(FN_MUL, '1, '0, '1, '1, 32'h8000_0000);
		drain();

		// wide modulus, zero coefficient
		write_reg(CFG_MOD, 32'hFFFF_FFFB);
		write_reg(CFG_A, 0);
		queue_op(FN_ADD, '1, '1, 32'h1234_5678, 32'h9ABC_DEF0, 0);
		queue_op(FN_DBL, 32'hDEAD_BEEF, 32'h0BAD_F00D, 0, 0, 0);
		queue_op(FN_MUL, 32'h1357_9BDF, 32'h2468_ACE0, 0, 0, 32'hFFFF_FFFF);
		drain();

		// degenerate moduli and modulus 3, maximal coefficient
		write_reg(CFG_A, '1);
		write_reg(CFG_MOD, 0);
		queue_op(FN_ADD, 1, 2, 3, 4, 5);
		queue_op(FN_MUL, 1, 2, 3, 4, 5);
		drain();
		write_reg(CFG_MOD, 1);
		queue_op(FN_DBL, 1, 2, 3, 4, 5);
		drain();
		write_reg(CFG_MOD, 3);
		queue_op(FN_DBL, 1, 2, 0, 0, 0);
		queue_op(FN_MUL, 2, 1, 0, 0, 13);
		drain();

		// random part: small prime with full idling
		write_reg(CFG_MOD, 10007);
		write_reg(CFG_A, $urandom);
		queue_random(20, 1);
		drain();

		// no idling on either side
		no_idle = 1;
		write_reg(CFG_MOD, 65521);
		write_reg(CFG_A, 2);
		queue_random(20, 1);
		drain();
		no_idle = 0;

		// sender pauses mid-stream until all results are back
		write_reg(CFG_MOD, 32'hFFFF_FFFB);
		write_reg(CFG_A, $urandom);
		queue_random(10, 1);
		wait (op_q.size() == 0);
		hold_req = 1;
		wait (result_q.size() == 0 && !req.valid);
		repeat (DRAIN_CYC) @(posedge clk);
		hold_req = 0;
		queue_random(20, 1);
		queue_random(3, 0);
		drain();

		// non-prime modulus
		write_reg(CFG_MOD, 221);
		queue_random(12, 1);
		drain();

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
